// File: hw/rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner: register
// indexes, the decoded configuration bundle and the per-cell control group.
// ----------------------------------------------------------------------------
package mbps_pkg;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int PAT_BYTES = 32;   // pattern bytes held by the register file
  localparam int PIDX_W    = 5;    // index into the pattern bytes
  localparam int OFS_W     = 32;   // byte offset / bytes seen
  localparam int CNT_W     = 16;   // match counter
  localparam int LEN_W     = 6;    // pattern length register
  localparam int CFG_W     = 64;   // widest configuration register
  localparam int CIDX_W    = 3;    // configuration register index

  // Configuration register indexes
  typedef logic [CIDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_PAT0 = 3'd0;
  localparam cfg_idx_t REG_PAT1 = 3'd1;
  localparam cfg_idx_t REG_PAT2 = 3'd2;
  localparam cfg_idx_t REG_PAT3 = 3'd3;
  localparam cfg_idx_t REG_MASK = 3'd4;
  localparam cfg_idx_t REG_LEN  = 3'd5;
  localparam cfg_idx_t REG_OCC  = 3'd6;

  // Decoded configuration seen by the scan logic
  typedef struct packed {
    logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
    logic [PAT_BYTES-1:0]             mask;
    logic [LEN_W-1:0]                 len_used;  // clamped to 1..PATTERN_MAX
    logic [CNT_W-1:0]                 occ;
  } cfg_t;

  // Control group driven into each window cell
  typedef struct packed {
    logic              shift;   // item accepted, window advances
    logic              cmp_en;  // this cell's byte takes part in the compare
    logic [BYTE_W-1:0] pat;     // pattern byte aligned to this cell
  } cell_ctl_t;

endpackage

// File: hw/rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: holds one byte of recent history, passes it to the
// next cell on every accepted item and compares the incoming byte against
// the pattern byte aligned to this position.
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [BYTE_W-1:0] byte_in,
  output logic [BYTE_W-1:0] byte_out,
  output logic              hit
);

  logic [BYTE_W-1:0] win_r;

  // History byte, shifted along the chain
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win_r <= byte_in;
    end
  end

  assign byte_out = win_r;

  // Compare the byte this cell takes in; wildcards and unused cells pass
  assign hit = !ctl.cmp_en || (byte_in == ctl.pat);

endmodule

// File: hw/rtl/mbps_cfg.sv
// ----------------------------------------------------------------------------
// mbps_cfg
// Configuration register file: pattern words, compare mask, pattern length
// and wanted occurrence. Unpacks the pattern bytes and clamps the length.
// ----------------------------------------------------------------------------
module mbps_cfg
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output cfg_t             cfg
);

  logic [3:0][CFG_W-1:0] pat_r;
  logic [PAT_BYTES-1:0]  mask_r;
  logic [LEN_W-1:0]      len_r;
  logic [CNT_W-1:0]      occ_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      mask_r <= '1;
      len_r  <= LEN_W'(1);
      occ_r  <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT0: pat_r[0] <= cfg_wdata;
        REG_PAT1: pat_r[1] <= cfg_wdata;
        REG_PAT2: pat_r[2] <= cfg_wdata;
        REG_PAT3: pat_r[3] <= cfg_wdata;
        REG_MASK: mask_r   <= cfg_wdata[PAT_BYTES-1:0];
        REG_LEN:  len_r    <= cfg_wdata[LEN_W-1:0];
        REG_OCC:  occ_r    <= cfg_wdata[CNT_W-1:0];
        default:  ;
      endcase
    end
  end

  // Unpack pattern bytes, eight per word, low byte first
  always_comb begin
    for (int k = 0; k < PAT_BYTES; k++) begin
      cfg.pattern[k] = pat_r[k / 8][(k % 8) * BYTE_W +: BYTE_W];
    end
  end

  assign cfg.mask = mask_r;
  assign cfg.occ  = occ_r;

  // Length zero acts as one; lengths past the window act as the window
  always_comb begin
    if (len_r == '0) begin
      cfg.len_used = LEN_W'(1);
    end else if (len_r > LEN_W'(PATTERN_MAX)) begin
      cfg.len_used = LEN_W'(PATTERN_MAX);
    end else begin
      cfg.len_used = len_r;
    end
  end

endmodule

// File: hw/rtl/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Wildcard byte pattern search over a byte stream, reporting the start
// offset of the Nth (possibly overlapping) match or not found at image end.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one image byte per item in in_tdata, in_tlast on the final byte.
//   out_* : at most one item per image. out_tuser = 1 with the match start
//           offset in out_tdata, or out_tuser = 0 with out_tdata = 0 when the
//           image ended before the wanted match.
//   cfg_* : register writes (pattern words, mask, length, occurrence); write
//           them between items.
// Throughput is one byte per cycle: the window is a chain of PATTERN_MAX
// cells that shift and compare in parallel, and the match counter updates
// in the same cycle. A result appears on out_* the cycle after the byte
// that completes it is accepted.
// The single output register drains while a new byte is taken; in_tready
// only drops while a result waits and out_tready is low.
// Reset (rst_n low, synchronous) clears the scan counters and the output
// valid flag and loads the register defaults; the next byte starts an
// image at offset 0, as does the byte after one flagged last.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] data_byte
  input  logic              in_tlast,   // last_byte
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OFS_W-1:0]  out_tdata,  // [31:0] match_offset
  output logic              out_tuser,  // [0] found
  // configuration
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  cfg_t cfg;

  logic                                in_acc;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0]  win;
  logic [PATTERN_MAX-1:0]              hit;
  logic                                all_hit;

  logic [OFS_W-1:0] bytes_r, bytes_nxt;
  logic [CNT_W-1:0] matches_r, matches_nxt;
  logic             reported_r, reported_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OFS_W-1:0] out_ofs_r, out_ofs_nxt;
  logic             out_found_r, out_found_nxt;

  logic             sat;
  logic [OFS_W-1:0] bytes_inc;
  logic [CNT_W-1:0] matches_inc;
  logic             enough;
  logic             match_now;
  logic             found_now;
  logic             emit;

  // Configuration registers
  mbps_cfg #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Window cell chain; cell j takes in the byte from j items ago and compares
  // it with pattern byte (len - 1 - j)
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    cell_ctl_t         ctl;
    logic [BYTE_W-1:0] byte_in;
    logic [LEN_W-1:0]  rel;
    logic              in_use;

    assign rel    = cfg.len_used - LEN_W'(1) - LEN_W'(j);
    assign in_use = LEN_W'(j) < cfg.len_used;

    assign ctl.shift  = in_acc;
    assign ctl.cmp_en = in_use && ((rel == '0) || cfg.mask[rel[PIDX_W-1:0]]);
    assign ctl.pat    = cfg.pattern[rel[PIDX_W-1:0]];

    if (j == 0) begin : g_head
      assign byte_in = in_tdata;
    end else begin : g_body
      assign byte_in = win[j-1];
    end

    mbps_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .byte_in  (byte_in),
      .byte_out (win[j]),
      .hit      (hit[j])
    );
  end

  assign all_hit = &hit;

  // Match qualification and counting
  always_comb begin
    sat         = &bytes_r;
    bytes_inc   = bytes_r + OFS_W'(1);
    matches_inc = matches_r + CNT_W'(1);
    enough      = bytes_inc >= OFS_W'(cfg.len_used);
    match_now   = !sat && enough && !reported_r && (cfg.occ != '0) && all_hit;
    found_now   = match_now && (matches_inc == cfg.occ);
    emit        = found_now || (in_tlast && !reported_r);

    bytes_nxt    = bytes_r;
    matches_nxt  = matches_r;
    reported_nxt = reported_r;
    if (in_acc) begin
      if (in_tlast) begin
        bytes_nxt    = '0;
        matches_nxt  = '0;
        reported_nxt = 1'b0;
      end else begin
        if (!sat) begin
          bytes_nxt = bytes_inc;
        end
        if (match_now) begin
          matches_nxt = matches_inc;
        end
        reported_nxt = reported_r || found_now;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ofs_nxt   = out_ofs_r;
    out_found_nxt = out_found_r;
    if (in_acc && emit) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = found_now;
      out_ofs_nxt   = found_now ? (bytes_inc - OFS_W'(cfg.len_used)) : '0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r     <= '0;
      matches_r   <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bytes_r     <= bytes_nxt;
      matches_r   <= matches_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ofs_r   <= out_ofs_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_ofs_r;
  assign out_tuser  = out_found_r;

`ifndef SYNTHESIS
  // A byte flagged last leaves the scan state cleared
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> (bytes_r == '0) && (matches_r == '0) && !reported_r)
    else $error("scan state not cleared after last byte");

  // A not-found result only comes from the final byte of an image
  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit && !found_now |-> in_tlast)
    else $error("not-found result without last byte");

  // A waiting result that is not taken blocks new bytes
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input accepted while result stalled");

  // Not-found results carry a zero offset
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-found result with nonzero offset");
`endif

endmodule

// File: verif/mbps_scan_checker.sv
// ----------------------------------------------------------------------------
// mbps_scan_checker
// Watches the byte stream, the result stream and the register port of the
// masked byte pattern scanner. It keeps its own copy of the registers and of
// the scan state, predicts the report for every accepted byte and compares
// each accepted result, field by field, with the oldest report still owed.
// ----------------------------------------------------------------------------
module mbps_scan_checker
  import mbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,
  input  logic              in_tlast,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OFS_W-1:0]  out_tdata,
  input  logic              out_tuser,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                mismatches,
  output int                pending,
  output int                reports_checked,
  output int                found_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              WIN_DEPTH  = 32;
  localparam int              REPORT_MAX = 10;
  localparam logic [OFS_W-1:0] SEEN_MAX  = '1;

  typedef struct packed {
    logic             found;
    logic [OFS_W-1:0] offset;
  } scan_report_t;

  // register copy
  logic [CFG_W-1:0]  pat_word [4];
  logic [31:0]       cmp_mask;
  logic [LEN_W-1:0]  len_reg;
  logic [CNT_W-1:0]  occ_reg;

  // scan state of the current image
  logic [BYTE_W-1:0] window [WIN_DEPTH];
  logic [OFS_W-1:0]  seen;
  logic [CNT_W-1:0]  hits;
  logic              done;

  scan_report_t expected_reports [$];

  initial begin
    mismatches      = 0;
    pending         = 0;
    reports_checked = 0;
    found_reports   = 0;
  end

  // length register clamped to 1..32
  function automatic int unsigned used_len();
    if (len_reg == 0) return 1;
    if (len_reg > WIN_DEPTH) return WIN_DEPTH;
    return len_reg;
  endfunction

  // does the newest n bytes of the window match the pattern
  function automatic logic window_hit(input int unsigned n);
    logic [BYTE_W-1:0] pb;
    for (int unsigned i = 0; i < n; i++) begin
      pb = pat_word[i / 8][(i % 8) * 8 +: 8];
      if ((i == 0 || cmp_mask[i]) && window[n - 1 - i] != pb) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_scan();
    foreach (window[j]) window[j] = '0;
    seen = '0;
    hits = '0;
    done = 1'b0;
  endtask

  // advance the scan by one byte; may owe one report
  task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned      n;
    logic [OFS_W-1:0] pos;
    scan_report_t     rep;
    n   = used_len();
    pos = seen;
    for (int j = WIN_DEPTH - 1; j > 0; j--) window[j] = window[j - 1];
    window[0] = b;
    // offset counter saturates; the saturated byte completes nothing
    if (pos != SEEN_MAX) begin
      seen = pos + 1'b1;
      if (seen >= n && !done && occ_reg != 0 && window_hit(n)) begin
        hits = hits + 1'b1;
        if (hits == occ_reg) begin
          rep.found  = 1'b1;
          rep.offset = seen - n;
          expected_reports.push_back(rep);
          done = 1'b1;
        end
      end
    end
    // image end: not found unless already reported, then start over
    if (last) begin
      if (!done) begin
        rep.found  = 1'b0;
        rep.offset = '0;
        expected_reports.push_back(rep);
      end
      clear_scan();
    end
  endtask

  task automatic check_report(input logic found, input logic [OFS_W-1:0] ofs);
    scan_report_t want;
    reports_checked++;
    if (found === 1'b1) found_reports++;
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("ERROR: %0t result with none expected: found=%0d offset=%0d",
                 $realtime, found, ofs);
    end else begin
      want = expected_reports.pop_front();
      if (found !== want.found || ofs !== want.offset) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: %0t result %0d: expected found=%0d offset=%0d, got found=%0d offset=%0d",
                   $realtime, reports_checked, want.found, want.offset, found, ofs);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (pat_word[w]) pat_word[w] = '0;
      cmp_mask = '1;
      len_reg  = 1;
      occ_reg  = 1;
      clear_scan();
      expected_reports.delete();
    end else begin
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_report(out_tuser, out_tdata);
      // a write counts from the next byte on
      if (cfg_we) begin
        case (cfg_index)
          REG_PAT0: pat_word[0] = cfg_wdata;
          REG_PAT1: pat_word[1] = cfg_wdata;
          REG_PAT2: pat_word[2] = cfg_wdata;
          REG_PAT3: pat_word[3] = cfg_wdata;
          REG_MASK: cmp_mask    = cfg_wdata[31:0];
          REG_LEN:  len_reg     = cfg_wdata[LEN_W-1:0];
          REG_OCC:  occ_reg     = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_reports.size();
  end

endmodule

// File: verif/tb_masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_scanner
// Drives images into the scanner under a series of pattern, mask, length and
// occurrence settings: a short hand-built set of corner images first, then
// random images built mostly from pattern copies with random wildcard bytes.
// Both stream sides idle and stall at random; mbps_scan_checker does the
// prediction and comparison, this module only gives the verdict.
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_scanner
  import mbps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int       ITEM_TARGET      = 1150;
  localparam int       LONG_HOLD_CYCLES = 120;
  localparam int       DRAIN_CYCLES     = 4;
  localparam int       TAIL_CYCLES      = 10;
  localparam int       WIN_DEPTH        = 32;
  localparam cfg_idx_t REG_SPARE        = 3'd7;  // decodes to no register

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [OFS_W-1:0]  out_tdata;
  logic              out_tuser;
  logic              cfg_we;
  cfg_idx_t          cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  int mismatches;
  int pending;
  int reports_checked;
  int found_reports;

  // stimulus bookkeeping
  logic [7:0]  pat_shadow [WIN_DEPTH];
  logic [31:0] mask_shadow;
  int          len_shadow;
  logic [7:0]  img_buf [$];
  logic        hold_off_req;
  int          bytes_sent;
  int          images_sent;
  int          settings_used;

  masked_byte_pattern_scanner #(.PATTERN_MAX(32)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  mbps_scan_checker scan_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .reports_checked (reports_checked),
    .found_reports   (found_reports)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("masked_byte_pattern_scanner regression: fail");
    $finish;
  end

  // mostly short gaps, a few long ones; none in burst mode
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // offer one byte, return at the edge that accepts it
  task automatic push_byte(input logic [7:0] b, input logic last, input int gap);
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_image(input bit burst);
    foreach (img_buf[k]) push_byte(img_buf[k], k == img_buf.size() - 1, pick_gap(burst));
    images_sent++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // stop offering and wait until every owed result has come out
  task automatic drain_results();
    @(negedge clk) in_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  // load all registers from the shadow copy; upper write bits are junk
  task automatic program_scan(input logic [5:0] len_raw, input logic [31:0] mask,
                              input logic [15:0] occ);
    logic [CFG_W-1:0] word;
    drain_results();
    // a byte that owes nothing may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int w = 0; w < 4; w++) begin
      for (int b = 0; b < 8; b++) word[b * 8 +: 8] = pat_shadow[w * 8 + b];
      write_reg(cfg_idx_t'(w), word);
    end
    write_reg(REG_MASK, {$urandom, mask});
    write_reg(REG_LEN, {$urandom, 26'($urandom), len_raw});
    write_reg(REG_OCC, {$urandom, 16'($urandom), occ});
    mask_shadow = mask;
    len_shadow  = (len_raw == 0) ? 1 : (len_raw > WIN_DEPTH) ? WIN_DEPTH : len_raw;
    settings_used++;
  endtask

  task automatic clear_pattern();
    foreach (pat_shadow[i]) pat_shadow[i] = 8'h00;
  endtask

  // random setting, extremes weighted in
  task automatic pick_setting();
    logic [5:0]  len_raw;
    logic [31:0] mask;
    logic [15:0] occ;
    int          r;
    r = $urandom_range(0, 5);
    foreach (pat_shadow[i]) begin
      case (r)
        0:       pat_shadow[i] = 8'h00;
        1:       pat_shadow[i] = 8'hFF;
        2:       pat_shadow[i] = ($urandom_range(0, 2) == 0) ? 8'h78 :
                                 ($urandom_range(0, 1) == 0) ? 8'hFF : 8'h00;
        default: pat_shadow[i] = 8'($urandom);
      endcase
    end
    r = $urandom_range(0, 9);
    if (r == 0)      len_raw = 6'($urandom_range(0, 1));
    else if (r == 1) len_raw = 6'd32;
    else if (r == 2) len_raw = 6'($urandom_range(33, 63));
    else             len_raw = 6'($urandom_range(2, 8));
    r = $urandom_range(0, 7);
    mask = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    r = $urandom_range(0, 9);
    if (r == 0)      occ = 16'h0000;
    else if (r == 1) occ = 16'hFFFF;
    else if (r == 2) occ = 16'($urandom);
    else             occ = 16'($urandom_range(1, 4));
    program_scan(len_raw, mask, occ);
  endtask

  // random image: pattern copies with random wildcards, stray pattern bytes
  // and noise; a noise image carries no deliberate copies
  task automatic build_image(input bit short_phase);
    logic [7:0] plan [$];
    int         img_len;
    int         r;
    bit         noise;
    noise = ($urandom_range(0, 7) == 0);
    if (short_phase)                      img_len = $urandom_range(2, 10);
    else if (len_shadow > 8)              img_len = $urandom_range(len_shadow - 6, 3 * len_shadow);
    else if ($urandom_range(0, 9) == 0)   img_len = $urandom_range(30, 60);
    else                                  img_len = $urandom_range(1, 24);
    img_buf.delete();
    while (img_buf.size() < img_len) begin
      if (plan.size() == 0) begin
        r = $urandom_range(0, 9);
        if (noise || r >= 7) begin
          plan.push_back(8'($urandom));
        end else if (r < 4) begin
          for (int i = 0; i < len_shadow; i++)
            plan.push_back((i == 0 || mask_shadow[i]) ? pat_shadow[i] : 8'($urandom));
        end else begin
          plan.push_back(pat_shadow[$urandom_range(0, len_shadow - 1)]);
        end
      end
      img_buf.push_back(plan.pop_front());
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int   r;
    int   n;
    logic v;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        @(negedge clk) out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60)      begin v = 1'b1; n = $urandom_range(1, 20); end
        else if (r < 90) begin v = 1'b0; n = $urandom_range(1, 3);  end
        else             begin v = 1'b0; n = $urandom_range(10, 40); end
        @(negedge clk) out_tready <= v;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // stimulus
  initial begin
    int n_img;
    bit first_phase;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_PAT0;
    cfg_wdata     = '0;
    hold_off_req  = 1'b0;
    bytes_sent    = 0;
    images_sent   = 0;
    settings_used = 0;
    clear_pattern();
    mask_shadow = '1;
    len_shadow  = 1;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset setting: single zero byte, match lands on the final byte
    img_buf = {8'hFF, 8'h00};
    send_image(0);

    // length 0 acts as 1; then occurrence 0 never reports a match
    pat_shadow[0] = 8'h78;
    program_scan(6'd0, 32'hFFFF_FFFF, 16'd1);
    img_buf = {8'h78};
    send_image(0);
    program_scan(6'd0, 32'hFFFF_FFFF, 16'd0);
    img_buf = {8'h78, 8'h78};
    send_image(0);

    // wildcard in the middle, mask bit 0 clear but byte 0 still compared
    pat_shadow[0] = 8'h5A;
    pat_shadow[1] = 8'h78;
    pat_shadow[2] = 8'hFF;
    program_scan(6'd3, 32'hFFFF_FFFC, 16'd1);
    img_buf = {8'h5A, 8'h00, 8'hFF, 8'h01};
    send_image(0);
    // image shorter than the pattern
    img_buf = {8'h5A, 8'h78};
    send_image(1);

    // overlapping matches, second one wanted, later ones silent
    clear_pattern();
    pat_shadow[0] = 8'hAA;
    pat_shadow[1] = 8'hAA;
    program_scan(6'd2, 32'hFFFF_FFFF, 16'd2);
    img_buf = {8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA};
    send_image(0);
    // counters restart: only one match here
    img_buf = {8'hAA, 8'hAA};
    send_image(0);

    // write to the spare index changes nothing
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_SPARE, '1);
    img_buf = {8'hAA, 8'hAA, 8'hAA};
    send_image(1);

    // random settings and images
    first_phase = 1'b1;
    while (bytes_sent < ITEM_TARGET) begin
      pick_setting();
      // first phase: short images while the result side holds off
      if (first_phase) begin
        hold_off_req = 1'b1;
        wait (!hold_off_req);
      end
      n_img = $urandom_range(3, 8);
      for (int k = 0; k < n_img && bytes_sent < ITEM_TARGET; k++) begin
        if ($urandom_range(0, 11) == 0) drain_results();
        build_image(first_phase);
        send_image(first_phase || $urandom_range(0, 9) < 3);
      end
      first_phase = 1'b0;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run: %0d bytes in %0d images under %0d register settings",
             bytes_sent, images_sent, settings_used);
    $display("run: %0d results compared, %0d found and %0d not found",
             reports_checked, found_reports, reports_checked - found_reports);
    if (mismatches == 0 && pending == 0) begin
      $display("masked_byte_pattern_scanner regression: pass");
    end else begin
      $display("masked_byte_pattern_scanner regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cell.sv
hw/rtl/mbps_cfg.sv
hw/rtl/masked_byte_pattern_scanner.sv
verif/mbps_scan_checker.sv
verif/tb_masked_byte_pattern_scanner.sv
